### hdl/msort_pkg.sv
// shared data width and type for the merge sorter
package msort_pkg;

  localparam int unsigned DataW = 32;

  typedef logic signed [DataW-1:0] msort_data_t;

endpackage

### hdl/merge_sorter.sv
// merge sorter top level: loads a set into memory, sorts it bottom-up, streams it out
// operation: loads one input beat per cycle; after the last beat the sort runs
//   ceil(log2 n) passes plus a closing check, each pass a setup state, then a read
//   and a compare state per item, in two ping-pong memories with one write and two
//   registered read ports; each result beat goes via ORD and OLD, held until taken
// throughput: one set at a time, no input accepted between the last beat and the final result
// reset: asynchronous, active low, clears the control state; memory contents stay undefined
module merge_sorter #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  msort_pkg::msort_data_t value_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output msort_pkg::msort_data_t sorted_value_o,
  output logic                  last_res_o,
  output logic                  overflow_o
);
  import msort_pkg::*;

  localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned WW = CW + 1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_ORD   = 3'd4;
  localparam logic [2:0] ST_OLD   = 3'd5;
  localparam logic [2:0] ST_OWAIT = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          src_q, src_d;
  logic [WW-1:0] w_q, w_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, mid_q, mid_d, hi_q, hi_d, k_q, k_d;
  logic          out_valid_q, out_valid_d;
  msort_data_t   out_data_q, out_data_d;
  logic          out_last_q, out_last_d;
  logic          out_ovf_q, out_ovf_d;

  msort_data_t   mem0 [MAX_ITEMS];
  msort_data_t   mem1 [MAX_ITEMS];
  msort_data_t   rda0_q, rdb0_q, rda1_q, rdb1_q;
  logic          we0, we1;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  msort_data_t   wdata;

  msort_data_t   da, db, merged;
  logic          take_a, in_acc, out_acc;
  logic [CW-1:0] base, ni, nj, mid_new, hi_new;
  logic [CW:0]   sum_mid;
  logic [CW+1:0] sum_hi;
  logic [CW:0]   k_inc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_q && out_ready_i;

  assign da = src_q ? rda1_q : rda0_q;
  assign db = src_q ? rdb1_q : rdb0_q;

  assign take_a = (i_q < mid_q) && ((j_q >= hi_q) || (da < db));
  assign merged = take_a ? da : db;
  assign ni     = take_a ? i_q + CW'(1) : i_q;
  assign nj     = take_a ? j_q : j_q + CW'(1);
  assign k_inc  = {1'b0, k_q} + (CW+1)'(1);

  // bounds of the next pair of runs, clipped to the set size
  assign base    = (state_q == ST_PASS) ? '0 : hi_q;
  assign sum_mid = (CW+1)'({1'b0, base}) + (CW+1)'(w_q);
  assign sum_hi  = (CW+2)'({1'b0, base}) + (CW+2)'({w_q, 1'b0});
  assign mid_new = (sum_mid > (CW+1)'(count_q)) ? count_q : sum_mid[CW-1:0];
  assign hi_new  = (sum_hi > (CW+2)'(count_q)) ? count_q : sum_hi[CW-1:0];

  assign raddr_a = (state_q == ST_ORD) ? k_q[AW-1:0] : i_q[AW-1:0];
  assign raddr_b = j_q[AW-1:0];

  always_comb begin
    we0   = 1'b0;
    we1   = 1'b0;
    waddr = k_q[AW-1:0];
    wdata = merged;
    if (state_q == ST_LOAD) begin
      we0   = in_acc && (count_q < MaxCount);
      waddr = count_q[AW-1:0];
      wdata = value_i;
    end else if (state_q == ST_CMP) begin
      we0 = src_q;
      we1 = !src_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[waddr] <= wdata;
    end
    rda0_q <= mem0[raddr_a];
    rdb0_q <= mem0[raddr_b];
  end

  always_ff @(posedge clk_i) begin
    if (we1) begin
      mem1[waddr] <= wdata;
    end
    rda1_q <= mem1[raddr_a];
    rdb1_q <= mem1[raddr_b];
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    src_d       = src_q;
    w_d         = w_q;
    i_d         = i_q;
    j_d         = j_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q < MaxCount) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_i) begin
            state_d = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        k_d = '0;
        if (w_q >= WW'(count_q)) begin
          state_d = ST_ORD;
        end else begin
          i_d     = '0;
          mid_d   = mid_new;
          j_d     = mid_new;
          hi_d    = hi_new;
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        k_d = k_inc[CW-1:0];
        i_d = ni;
        j_d = nj;
        if (k_inc == (CW+1)'(count_q)) begin
          src_d   = !src_q;
          w_d     = {w_q[WW-2:0], 1'b0};
          state_d = ST_PASS;
        end else begin
          if ((ni == mid_q) && (nj == hi_q)) begin
            i_d   = hi_q;
            mid_d = mid_new;
            j_d   = mid_new;
            hi_d  = hi_new;
          end
          state_d = ST_RD;
        end
      end
      ST_ORD: begin
        state_d = ST_OLD;
      end
      ST_OLD: begin
        out_valid_d = 1'b1;
        out_data_d  = da;
        out_last_d  = (k_inc == (CW+1)'(count_q));
        out_ovf_d   = ovf_q;
        state_d     = ST_OWAIT;
      end
      ST_OWAIT: begin
        if (out_acc) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            src_d   = 1'b0;
            w_d     = WW'(1);
            state_d = ST_LOAD;
          end else begin
            k_d     = k_inc[CW-1:0];
            state_d = ST_ORD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      src_q       <= 1'b0;
      w_q         <= WW'(1);
      i_q         <= '0;
      j_q         <= '0;
      mid_q       <= '0;
      hi_q        <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      src_q       <= src_d;
      w_q         <= w_d;
      i_q         <= i_d;
      j_q         <= j_d;
      mid_q       <= mid_d;
      hi_q        <= hi_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_ready_o     = (state_q == ST_LOAD);
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_data_q;
  assign last_res_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

  a_valid_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == ST_OWAIT)
    else $error("result beat shown outside the output wait state");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("loading while a result beat is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("kept item count beyond capacity");

  a_merge_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMP |-> (k_q < count_q) && (i_q <= mid_q) && (j_q <= hi_q))
    else $error("merge index out of its run");

  a_set_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_last_q |=> state_q == ST_LOAD && count_q == '0 && !ovf_q)
    else $error("store not cleared after the final result beat");

endmodule
